// ===== rtl/mcst_pkg.sv =====
// memory card sector transfer: shared codes and frame constants
// no dependencies; used by memory_card_sector_transfer_top
package mcst_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_RX      = 2'd1,
        FUNC_TIMEOUT = 2'd2,
        FUNC_UNUSED  = 2'd3
    } t_func;

    // final transfer status
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_IO_ERROR = 3'd2,
        ST_MISSING  = 3'd3,
        ST_CHANGED  = 3'd4
    } t_status;

    // configuration register indexes
    localparam logic CFG_SESSION_OPEN = 1'b0;
    localparam logic CFG_CHANGE_GUARD = 1'b1;

    // bytes sent and expected on the wire
    localparam logic [7:0] CMD_HEADER  = 8'h81;
    localparam logic [7:0] CMD_WRITE   = 8'h57;
    localparam logic [7:0] CMD_READ    = 8'h52;
    localparam logic [7:0] ACK_ID1     = 8'h5a;
    localparam logic [7:0] ACK_ID2     = 8'h5d;
    localparam logic [7:0] ACK_CMD     = 8'h5c;
    localparam logic [7:0] END_GOOD    = 8'h47;

    // last frame position for each direction (frame length minus one)
    localparam logic [7:0] LAST_WRITE  = 8'd137;
    localparam logic [7:0] LAST_READ   = 8'd139;

endpackage

// ===== rtl/memory_card_sector_transfer_top.sv =====
// memory card sector transfer: framer for one sector read or write and
// checker of the card reply, byte by byte; depends on mcst_pkg
//
// datapath: an input beat passes the input register, then the per-byte framing
//   logic into the result register
// throughput: one input beat per cycle while the receiver keeps up, set by the single
//   result register that the framing logic writes every cycle it is free or being drained
// reset: synchronous, active low; clears transfer state, config and the
//   valid flags of both registers
module memory_card_sector_transfer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,

    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // sector[9:0], writing[10], write_byte[18:11],
                                       // rx_byte[26:19], zero[31:27]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]

    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // tx_byte[7:0], read_byte[15:8], status[18:16],
                                       // zero[23:19]
    output logic [1:0]  m_axis_tuser,  // tx_valid[0], read_valid[1]
    output logic        m_axis_tlast   // done_res
);

    // configuration registers
    logic r_session_open;
    logic r_change_guard;

    // input register
    logic                 r_in_valid;
    mcst_pkg::t_func      r_in_func;
    logic [9:0]           r_in_sector;
    logic                 r_in_writing;
    logic [7:0]           r_in_wbyte;
    logic [7:0]           r_in_rx;

    // transfer state
    logic       r_busy,        n_busy;
    logic [7:0] r_byte_index,  n_byte_index;
    logic       r_write_mode,  n_write_mode;
    logic [9:0] r_sector,      n_sector;
    logic [7:0] r_send_sum,    n_send_sum;
    logic [7:0] r_reply_sum,   n_reply_sum;
    logic       r_frame_error, n_frame_error;

    // result register
    logic                 r_out_valid;
    logic [7:0]           r_out_tx;
    logic                 r_out_tx_valid;
    logic [7:0]           r_out_rd;
    logic                 r_out_rd_valid;
    logic                 r_out_done;
    mcst_pkg::t_status    r_out_status;

    // framing logic results
    logic                 w_fire;
    logic                 w_res_valid;
    logic [7:0]           w_tx;
    logic                 w_tx_valid;
    logic [7:0]           w_rd;
    logic                 w_rd_valid;
    logic                 w_done;
    mcst_pkg::t_status    w_status;
    logic [7:0]           w_last_pos;
    logic [7:0]           w_pos;
    logic [7:0]           w_sec_hi;
    logic [7:0]           w_sec_lo;

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_open <= 1'b0;
            r_change_guard <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcst_pkg::CFG_SESSION_OPEN: r_session_open <= i_cfg_data;
                default:                    r_change_guard <= i_cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func    <= mcst_pkg::t_func'(s_axis_tuser);
            r_in_sector  <= s_axis_tdata[9:0];
            r_in_writing <= s_axis_tdata[10];
            r_in_wbyte   <= s_axis_tdata[18:11];
            r_in_rx      <= s_axis_tdata[26:19];
        end
    end

    // per-byte framing and reply checks
    assign w_last_pos = r_write_mode ? mcst_pkg::LAST_WRITE : mcst_pkg::LAST_READ;
    assign w_pos      = r_byte_index + 8'd1;
    assign w_sec_hi   = {6'd0, r_sector[9:8]};
    assign w_sec_lo   = r_sector[7:0];

    always_comb begin
        n_busy        = r_busy;
        n_byte_index  = r_byte_index;
        n_write_mode  = r_write_mode;
        n_sector      = r_sector;
        n_send_sum    = r_send_sum;
        n_reply_sum   = r_reply_sum;
        n_frame_error = r_frame_error;
        w_res_valid   = 1'b0;
        w_tx          = 8'd0;
        w_tx_valid    = 1'b0;
        w_rd          = 8'd0;
        w_rd_valid    = 1'b0;
        w_done        = 1'b0;
        w_status      = mcst_pkg::ST_OK;

        case (r_in_func)
            // start: open a new frame or fail without a session
            mcst_pkg::FUNC_START: begin
                w_res_valid = 1'b1;
                if (!r_session_open) begin
                    n_busy   = 1'b0;
                    w_done   = 1'b1;
                    w_status = mcst_pkg::ST_IO_ERROR;
                end else begin
                    n_busy        = 1'b1;
                    n_byte_index  = 8'd0;
                    n_write_mode  = r_in_writing;
                    n_sector      = r_in_sector;
                    n_send_sum    = 8'd0;
                    n_reply_sum   = 8'd0;
                    n_frame_error = 1'b0;
                    w_tx          = mcst_pkg::CMD_HEADER;
                    w_tx_valid    = 1'b1;
                end
            end

            // timeout while busy: card missing on the first two bytes, else a timeout
            mcst_pkg::FUNC_TIMEOUT: begin
                if (r_busy) begin
                    n_busy      = 1'b0;
                    w_res_valid = 1'b1;
                    w_done      = 1'b1;
                    w_status    = (r_byte_index < 8'd2) ? mcst_pkg::ST_MISSING
                                                        : mcst_pkg::ST_TIMEOUT;
                end
            end

            // reply byte
            mcst_pkg::FUNC_RX: begin
                if (r_busy) begin
                    w_res_valid = 1'b1;
                    if (r_byte_index == 8'd1 && r_change_guard && r_in_rx[3]) begin
                        n_busy   = 1'b0;
                        w_done   = 1'b1;
                        w_status = mcst_pkg::ST_CHANGED;
                    end else begin
                        // common frame checks
                        if (r_byte_index == 8'd2 && r_in_rx != mcst_pkg::ACK_ID1)
                            n_frame_error = 1'b1;
                        if (r_byte_index == 8'd3 && r_in_rx != mcst_pkg::ACK_ID2)
                            n_frame_error = 1'b1;
                        if (r_byte_index == w_last_pos && r_in_rx != mcst_pkg::END_GOOD)
                            n_frame_error = 1'b1;
                        if (r_write_mode) begin
                            if (r_byte_index == 8'd135 && r_in_rx != mcst_pkg::ACK_CMD)
                                n_frame_error = 1'b1;
                            if (r_byte_index == 8'd136 && r_in_rx != mcst_pkg::ACK_ID2)
                                n_frame_error = 1'b1;
                        end else begin
                            if (r_byte_index == 8'd6 && r_in_rx != mcst_pkg::ACK_CMD)
                                n_frame_error = 1'b1;
                            if (r_byte_index == 8'd7 && r_in_rx != mcst_pkg::ACK_ID2)
                                n_frame_error = 1'b1;
                            if (r_byte_index == 8'd8 && r_in_rx != w_sec_hi)
                                n_frame_error = 1'b1;
                            if (r_byte_index == 8'd9 && r_in_rx != w_sec_lo)
                                n_frame_error = 1'b1;
                            if (r_byte_index >= 8'd8 && r_byte_index <= 8'd137)
                                n_reply_sum = r_reply_sum ^ r_in_rx;
                            if (r_byte_index == 8'd138 && r_in_rx != r_reply_sum)
                                n_frame_error = 1'b1;
                            if (r_byte_index >= 8'd10 && r_byte_index <= 8'd137) begin
                                w_rd       = r_in_rx;
                                w_rd_valid = 1'b1;
                            end
                        end

                        if (r_byte_index >= w_last_pos) begin
                            // end of frame
                            n_busy   = 1'b0;
                            w_done   = 1'b1;
                            w_status = n_frame_error ? mcst_pkg::ST_IO_ERROR
                                                     : mcst_pkg::ST_OK;
                        end else begin
                            // next byte to send
                            n_byte_index = w_pos;
                            w_tx_valid   = 1'b1;
                            case (w_pos)
                                8'd1: w_tx = r_write_mode ? mcst_pkg::CMD_WRITE
                                                          : mcst_pkg::CMD_READ;
                                8'd4: begin
                                    w_tx       = w_sec_hi;
                                    n_send_sum = r_send_sum ^ w_sec_hi;
                                end
                                8'd5: begin
                                    w_tx       = w_sec_lo;
                                    n_send_sum = r_send_sum ^ w_sec_lo;
                                end
                                default: begin
                                    if (r_write_mode && w_pos >= 8'd6 && w_pos <= 8'd133) begin
                                        w_tx       = r_in_wbyte;
                                        n_send_sum = r_send_sum ^ r_in_wbyte;
                                    end else if (r_write_mode && w_pos == 8'd134) begin
                                        w_tx = r_send_sum;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end

            default: begin
                // unused kind: no result
            end
        endcase
    end

    // transfer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_byte_index  <= 8'd0;
            r_write_mode  <= 1'b0;
            r_sector      <= 10'd0;
            r_send_sum    <= 8'd0;
            r_reply_sum   <= 8'd0;
            r_frame_error <= 1'b0;
        end else if (w_fire) begin
            r_busy        <= n_busy;
            r_byte_index  <= n_byte_index;
            r_write_mode  <= n_write_mode;
            r_sector      <= n_sector;
            r_send_sum    <= n_send_sum;
            r_reply_sum   <= n_reply_sum;
            r_frame_error <= n_frame_error;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out_tx       <= w_tx;
            r_out_tx_valid <= w_tx_valid;
            r_out_rd       <= w_rd;
            r_out_rd_valid <= w_rd_valid;
            r_out_done     <= w_done;
            r_out_status   <= w_status;
        end
    end

    // output beat packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_status, r_out_rd, r_out_tx};
    assign m_axis_tuser  = {r_out_rd_valid, r_out_tx_valid};
    assign m_axis_tlast  = r_out_done;

    // a finished transfer leaves the block idle
    a_done_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid && w_done) |=> !r_busy)
        else $error("busy still set after a final result");

    // position never runs past the longer frame
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_byte_index <= mcst_pkg::LAST_READ))
        else $error("byte index beyond frame");

    // a byte to send and a final status never share a beat
    a_tx_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_tx_valid && r_out_done))
        else $error("tx byte on a final beat");

    // status is only nonzero on a final beat
    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> (r_out_status == mcst_pkg::ST_OK))
        else $error("status on a non-final beat");

    // write transfers never produce read payload
    a_no_read_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_rd_valid) |-> (r_busy && !r_write_mode))
        else $error("read payload outside a read transfer");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for memory_card_sector_transfer_top: stream-driven
// sector reads and writes, checked beat by beat against an in-bench predictor
// depends on rtl/mcst_pkg.sv and rtl/memory_card_sector_transfer_top.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    // one input beat, unpacked
    typedef struct packed {
        mcst_pkg::t_func fn;
        logic [9:0]      sector;
        logic            writing;
        logic [7:0]      wbyte;
        logic [7:0]      rx;
    } t_card_beat;

    // one result beat, unpacked
    typedef struct packed {
        logic [7:0]        tx;
        logic              txv;
        logic [7:0]        rd;
        logic              rdv;
        logic              done;
        mcst_pkg::t_status st;
    } t_xfer_beat;

    // transfer predictor and queue of expected result beats
    class sector_scoreboard;
        bit         session_on;
        bit         guard_on;
        bit         busy;
        logic [7:0] pos;
        bit         wr_mode;
        logic [9:0] sector_q;
        logic [7:0] send_xor;
        logic [7:0] reply_xor;
        bit         bad_frame;
        t_xfer_beat pending[$];
        int         errors;
        int         n_in;
        int         n_out;
        int         n_payload;
        int         endings[5];

        function void set_reg(logic idx, logic val);
            if (idx == mcst_pkg::CFG_SESSION_OPEN) session_on = val;
            else guard_on = val;
        endfunction

        // byte sent at frame position p, folding sector and payload into the sum
        function logic [7:0] tx_for_position(logic [7:0] p, logic [7:0] wb);
            logic [7:0] b;
            b = 8'h00;
            case (p)
                0: b = mcst_pkg::CMD_HEADER;
                1: b = wr_mode ? mcst_pkg::CMD_WRITE : mcst_pkg::CMD_READ;
                4: begin
                    b = {6'd0, sector_q[9:8]};
                    send_xor ^= b;
                end
                5: begin
                    b = sector_q[7:0];
                    send_xor ^= b;
                end
                default: begin
                    if (wr_mode && p >= 6 && p <= 133) begin
                        b = wb;
                        send_xor ^= b;
                    end else if (wr_mode && p == 134) begin
                        b = send_xor;
                    end
                end
            endcase
            return b;
        endfunction

        // accepted input beat: advance the transfer, queue what it yields
        function void note_beat(t_card_beat it);
            t_xfer_beat r;
            logic [7:0] last;
            r = '0;
            n_in++;
            if (it.fn == mcst_pkg::FUNC_START) begin
                if (!session_on) begin
                    busy = 0;
                    r.done = 1;
                    r.st = mcst_pkg::ST_IO_ERROR;
                end else begin
                    busy = 1;
                    pos = 0;
                    wr_mode = it.writing;
                    sector_q = it.sector;
                    send_xor = 0;
                    reply_xor = 0;
                    bad_frame = 0;
                    r.tx = tx_for_position(8'd0, it.wbyte);
                    r.txv = 1;
                end
                pending.push_back(r);
                return;
            end
            if (!busy || it.fn == mcst_pkg::FUNC_UNUSED) return;
            if (it.fn == mcst_pkg::FUNC_TIMEOUT) begin
                busy = 0;
                r.done = 1;
                r.st = (pos < 2) ? mcst_pkg::ST_MISSING : mcst_pkg::ST_TIMEOUT;
                pending.push_back(r);
                return;
            end
            // reply byte for position pos
            last = wr_mode ? mcst_pkg::LAST_WRITE : mcst_pkg::LAST_READ;
            if (pos == 1 && guard_on && it.rx[3]) begin
                busy = 0;
                r.done = 1;
                r.st = mcst_pkg::ST_CHANGED;
                pending.push_back(r);
                return;
            end
            if (pos == 2 && it.rx != mcst_pkg::ACK_ID1) bad_frame = 1;
            if (pos == 3 && it.rx != mcst_pkg::ACK_ID2) bad_frame = 1;
            if (pos == last && it.rx != mcst_pkg::END_GOOD) bad_frame = 1;
            if (wr_mode) begin
                if (pos == 135 && it.rx != mcst_pkg::ACK_CMD) bad_frame = 1;
                if (pos == 136 && it.rx != mcst_pkg::ACK_ID2) bad_frame = 1;
            end else begin
                if (pos == 6 && it.rx != mcst_pkg::ACK_CMD) bad_frame = 1;
                if (pos == 7 && it.rx != mcst_pkg::ACK_ID2) bad_frame = 1;
                if (pos == 8 && it.rx != {6'd0, sector_q[9:8]}) bad_frame = 1;
                if (pos == 9 && it.rx != sector_q[7:0]) bad_frame = 1;
                if (pos >= 8 && pos <= 137) reply_xor ^= it.rx;
                if (pos == 138 && it.rx != reply_xor) bad_frame = 1;
                if (pos >= 10 && pos <= 137) begin
                    r.rd = it.rx;
                    r.rdv = 1;
                end
            end
            if (pos == last) begin
                busy = 0;
                r.done = 1;
                r.st = bad_frame ? mcst_pkg::ST_IO_ERROR : mcst_pkg::ST_OK;
            end else begin
                pos = pos + 1;
                r.tx = tx_for_position(pos, it.wbyte);
                r.txv = 1;
            end
            pending.push_back(r);
        endfunction

        function void compare_field(string what, int unsigned e, int unsigned g);
            if (e != g) begin
                errors++;
                if (errors <= 200)
                    $display("%0t ns: mismatch on %s: expected %0h, actual %0h",
                             $time, what, e, g);
                if (errors == 200)
                    $display("further mismatches counted but not shown");
            end
        endfunction

        // accepted result beat against the oldest expectation
        function void check_beat(t_xfer_beat got);
            t_xfer_beat exp;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with nothing expected: expected none, actual %h",
                         $time, got);
                return;
            end
            exp = pending.pop_front();
            n_out++;
            if (exp.rdv) n_payload++;
            if (exp.done) endings[exp.st]++;
            compare_field("tx_byte", exp.tx, got.tx);
            compare_field("tx_valid", exp.txv, got.txv);
            compare_field("read_byte", exp.rd, got.rd);
            compare_field("read_valid", exp.rdv, got.rdv);
            compare_field("done", exp.done, got.done);
            compare_field("status", exp.st, got.st);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // sector[9:0], writing[10], write_byte[18:11],
                                      // rx_byte[26:19], zero[31:27]
    logic [1:0]  s_axis_tuser = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // tx_byte[7:0], read_byte[15:8], status[18:16],
                                      // zero[23:19]
    logic [1:0]  m_axis_tuser;        // tx_valid[0], read_valid[1]
    logic        m_axis_tlast;        // done_res

    sector_scoreboard sb = new();
    t_xfer_beat       seen_beat;
    int unsigned      cycle_count = 0;
    int               tx_idle_pct = 23;
    int               rx_idle_pct = 74;
    int               n_sent = 0;
    bit               cur_open = 0;
    bit               cur_guard = 0;

    memory_card_sector_transfer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_beat.tx   = m_axis_tdata[7:0];
            seen_beat.rd   = m_axis_tdata[15:8];
            seen_beat.st   = mcst_pkg::t_status'(m_axis_tdata[18:16]);
            seen_beat.txv  = m_axis_tuser[0];
            seen_beat.rdv  = m_axis_tuser[1];
            seen_beat.done = m_axis_tlast;
            sb.check_beat(seen_beat);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** memory_card_sector_transfer_top: FAILED **");
            $finish;
        end
    end

    // one input beat, with random gaps ahead of it
    task automatic send_item(mcst_pkg::t_func fn, logic [9:0] sec, logic wr,
                             logic [7:0] wb, logic [7:0] rx);
        t_card_beat it;
        it = '{fn: fn, sector: sec, writing: wr, wbyte: wb, rx: rx};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, rx, wb, wr, sec};
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(it);
        n_sent++;
    endtask

    task automatic send_rx(logic [7:0] rx);
        send_item(mcst_pkg::FUNC_RX, 10'($urandom), 1'($urandom), 8'($urandom), rx);
    endtask

    // let every expected beat arrive, then cover ignored beats still in flight
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(bit open_val, bit guard_val);
        write_reg(mcst_pkg::CFG_SESSION_OPEN, open_val);
        write_reg(mcst_pkg::CFG_CHANGE_GUARD, guard_val);
        cur_open  = open_val;
        cur_guard = guard_val;
    endtask

    // reply a healthy card gives at position p
    function automatic logic [7:0] good_reply(int p, bit wr, logic [9:0] sec,
                                              logic [7:0] xsum);
        logic [7:0] r;
        r = 8'($urandom);
        if (p == 1 && cur_guard) r[3] = 1'b0;
        if (p == 2) r = mcst_pkg::ACK_ID1;
        if (p == 3) r = mcst_pkg::ACK_ID2;
        if (wr) begin
            if (p == 135) r = mcst_pkg::ACK_CMD;
            if (p == 136) r = mcst_pkg::ACK_ID2;
            if (p == 137) r = mcst_pkg::END_GOOD;
        end else begin
            if (p == 6) r = mcst_pkg::ACK_CMD;
            if (p == 7) r = mcst_pkg::ACK_ID2;
            if (p == 8) r = {6'd0, sec[9:8]};
            if (p == 9) r = sec[7:0];
            if (p == 138) r = xsum;
            if (p == 139) r = mcst_pkg::END_GOOD;
        end
        return r;
    endfunction

    // one transfer: stops early at end_at (timeout there if end_timeout)
    task automatic run_transfer(bit wr, logic [9:0] sec, int corrupt_pct, int end_at,
                                bit end_timeout, bit set_change);
        int         last;
        logic [7:0] rx;
        logic [7:0] xsum;
        last = wr ? mcst_pkg::LAST_WRITE : mcst_pkg::LAST_READ;
        xsum = 8'h00;
        send_item(mcst_pkg::FUNC_START, sec, wr, 8'($urandom), 8'($urandom));
        if (!cur_open) return;
        for (int p = 0; p <= last; p++) begin
            if (p == end_at) begin
                if (end_timeout)
                    send_item(mcst_pkg::FUNC_TIMEOUT, 10'($urandom), 1'($urandom),
                              8'($urandom), 8'($urandom));
                return;
            end
            rx = good_reply(p, wr, sec, xsum);
            if ($urandom_range(99) < corrupt_pct) rx = 8'($urandom);
            if (p == 1 && set_change) rx[3] = 1'b1;
            send_rx(rx);
            if (p >= 8 && p <= 137) xsum ^= rx;
            if (p == 1 && cur_guard && rx[3]) return;
        end
    endtask

    // random phase: mostly whole transfers, plus aborts, restarts and noise
    task automatic run_phase(bit open_val, bit guard_val, int tx_pct, int rx_pct,
                             int budget);
        int         target;
        int         pick;
        int         last;
        int         corrupt;
        bit         wr;
        logic [9:0] sec;
        drain();
        set_config(open_val, guard_val);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = n_sent + budget;
        while (n_sent < target) begin
            if ($urandom_range(29) == 0) drain();
            pick = $urandom_range(99);
            wr   = 1'($urandom);
            last = wr ? mcst_pkg::LAST_WRITE : mcst_pkg::LAST_READ;
            case ($urandom_range(7))
                0:       sec = 10'd0;
                1:       sec = 10'h3ff;
                default: sec = 10'($urandom);
            endcase
            case ($urandom_range(3))
                2:       corrupt = 1;
                3:       corrupt = 4;
                default: corrupt = 0;
            endcase
            if (pick < 50) begin
                run_transfer(wr, sec, corrupt, -1, 1'b0, 1'b0);
            end else if (pick < 70) begin
                // timeout, mostly near the head of the frame
                run_transfer(wr, sec, corrupt,
                             $urandom_range(1) ? $urandom_range(9) : $urandom_range(last),
                             1'b1, 1'b0);
            end else if (pick < 80) begin
                // left hanging, so the next start lands while busy
                run_transfer(wr, sec, corrupt, $urandom_range(last), 1'b0, 1'b0);
            end else if (pick < 88) begin
                run_transfer(wr, sec, corrupt, -1, 1'b0, 1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(mcst_pkg::t_func'($urandom_range(3)), 10'($urandom),
                              1'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        // close any transfer still open
        send_item(mcst_pkg::FUNC_TIMEOUT, 10'($urandom), 1'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // session closed after reset: start fails, stray beats are dropped
        send_item(mcst_pkg::FUNC_START, 10'd0, 1'b0, 8'h00, 8'h00);
        send_item(mcst_pkg::FUNC_RX, 10'h3ff, 1'b1, 8'hff, 8'hff);
        send_item(mcst_pkg::FUNC_TIMEOUT, 10'd0, 1'b0, 8'h00, 8'h00);
        send_item(mcst_pkg::FUNC_UNUSED, 10'h3ff, 1'b1, 8'hff, 8'hff);
        drain();
        set_config(1'b1, 1'b1);

        // card changed flag on reply byte 1
        send_item(mcst_pkg::FUNC_START, 10'h3ff, 1'b1, 8'hff, 8'h00);
        send_rx(8'hff);
        send_rx(8'h08);
        // timeout on byte 0 and on byte 1: card missing
        send_item(mcst_pkg::FUNC_START, 10'h2aa, 1'b0, 8'h00, 8'h00);
        send_item(mcst_pkg::FUNC_TIMEOUT, 10'd0, 1'b0, 8'h00, 8'h00);
        send_item(mcst_pkg::FUNC_START, 10'h3ff, 1'b0, 8'hff, 8'hff);
        send_rx(8'h00);
        send_item(mcst_pkg::FUNC_TIMEOUT, 10'h3ff, 1'b1, 8'hff, 8'hff);
        // timeout further into a write frame
        send_item(mcst_pkg::FUNC_START, 10'h155, 1'b1, 8'h00, 8'h00);
        send_rx(8'h00);
        send_rx(8'hf7);
        send_rx(mcst_pkg::ACK_ID1);
        send_item(mcst_pkg::FUNC_TIMEOUT, 10'd0, 1'b0, 8'h00, 8'h00);
        // restart while busy, unused code mid-transfer, reply when idle
        send_item(mcst_pkg::FUNC_START, 10'd5, 1'b0, 8'h00, 8'h00);
        send_rx(8'h00);
        send_item(mcst_pkg::FUNC_START, 10'd6, 1'b1, 8'h5a, 8'h00);
        send_item(mcst_pkg::FUNC_UNUSED, 10'd0, 1'b0, 8'h00, 8'h00);
        send_item(mcst_pkg::FUNC_TIMEOUT, 10'd0, 1'b0, 8'h00, 8'h00);
        send_rx(8'h55);

        run_phase(1'b1, 1'b0, 23, 74, 90);
        run_phase(1'b1, 1'b1, 23, 74, 90);
        run_phase(1'b0, 1'b0, 74, 23, 30);
        run_phase(1'b1, 1'b1, 74, 23, 90);
        run_phase(1'b0, 1'b1, 0, 0, 30);
        run_phase(1'b1, 1'b0, 0, 0, 90);

        drain();
        repeat (8) @(posedge i_clk);
        $display("run: %0d input beats, %0d result beats, %0d read payload beats",
                 n_sent, sb.n_out, sb.n_payload);
        $display("endings: ok %0d, timeout %0d, io error %0d, missing %0d, changed %0d",
                 sb.endings[mcst_pkg::ST_OK], sb.endings[mcst_pkg::ST_TIMEOUT],
                 sb.endings[mcst_pkg::ST_IO_ERROR], sb.endings[mcst_pkg::ST_MISSING],
                 sb.endings[mcst_pkg::ST_CHANGED]);
        if (sb.errors == 0) begin
            $display("** memory_card_sector_transfer_top: PASSED **");
        end else begin
            $display("** memory_card_sector_transfer_top: FAILED **");
        end
        $finish;
    end
endmodule
